FILE: rtl/core/bmhq_pkg.sv
package bmhq_pkg;

  // heap geometry
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned SlotW      = $clog2(MaxEntries);
  localparam int unsigned CountW     = $clog2(MaxEntries + 1);
  localparam int unsigned DataW      = 32;

  // configuration port
  localparam int unsigned PaddrW     = 2;
  localparam int unsigned PdataW     = 32;
  localparam logic [CountW-1:0] CapResetVal = CountW'(MaxEntries);

  // request kinds
  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop  = 1'b1;

  // result status codes
  localparam logic [1:0] StatDone  = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  // controller states
  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StUpChk  = 8'b0000_0010,
    StUpCmp  = 8'b0000_0100,
    StDnLast = 8'b0000_1000,
    StDnChk  = 8'b0001_0000,
    StDnCmp  = 8'b0010_0000,
    StFin    = 8'b0100_0000,
    StDone   = 8'b1000_0000
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic       set_stat;
    logic [1:0] stat;
    logic       load_push;
    logic       load_pop;
    logic       rd_up;
    logic       rd_dn;
    logic       take_last;
    logic       move_up;
    logic       move_down;
    logic       write_final;
    logic       load_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic count_zero;
    logic count_one;
    logic at_root;
    logic up_swap;
    logic has_left;
    logic down_swap;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/bmhq_if.sv
interface bmhq_req_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [DataW-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink (input valid, req_type, push_value, output ready);
endinterface

interface bmhq_rsp_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [DataW-1:0] min_value;
  logic [CountW-1:0]       entry_count;
  logic                    is_empty;

  modport source (output valid, status, min_value, entry_count, is_empty, input ready);
  modport sink (input valid, status, min_value, entry_count, is_empty, output ready);
endinterface

FILE: rtl/core/bmhq_ctrl.sv
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_req_type_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  // sequencing of one request
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.set_stat = 1'b1;
          if (in_req_type_i == ReqPush) begin
            if (stat_i.full) begin
              cmd_o.stat = StatFull;
              state_d    = StDone;
            end else begin
              cmd_o.stat      = StatDone;
              cmd_o.load_push = 1'b1;
              state_d         = StUpChk;
            end
          end else begin
            if (stat_i.count_zero) begin
              cmd_o.stat = StatEmpty;
              state_d    = StDone;
            end else begin
              cmd_o.stat     = StatDone;
              cmd_o.load_pop = 1'b1;
              state_d        = stat_i.count_one ? StDone : StDnLast;
            end
          end
        end
      end
      StUpChk: begin
        if (stat_i.at_root) begin
          state_d = StFin;
        end else begin
          cmd_o.rd_up = 1'b1;
          state_d     = StUpCmp;
        end
      end
      StUpCmp: begin
        if (stat_i.up_swap) begin
          cmd_o.move_up = 1'b1;
          state_d       = StUpChk;
        end else begin
          state_d = StFin;
        end
      end
      StDnLast: begin
        cmd_o.take_last = 1'b1;
        state_d         = StDnChk;
      end
      StDnChk: begin
        if (stat_i.has_left) begin
          cmd_o.rd_dn = 1'b1;
          state_d     = StDnCmp;
        end else begin
          state_d = StFin;
        end
      end
      StDnCmp: begin
        if (stat_i.down_swap) begin
          cmd_o.move_down = 1'b1;
          state_d         = StDnChk;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.write_final = 1'b1;
        state_d           = StDone;
      end
      StDone: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/bmhq_dpath.sv
module bmhq_dpath
  import bmhq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic [CountW-1:0]       limit_i,
  input  logic signed [DataW-1:0] push_value_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [1:0]              out_status_o,
  output logic signed [DataW-1:0] out_min_value_o,
  output logic [CountW-1:0]       out_entry_count_o,
  output logic                    out_is_empty_o
);

  // heap storage, undefined until written
  logic signed [DataW-1:0] mem_q [MaxEntries];

  logic [CountW-1:0]       count_q, count_d;
  logic [CountW-1:0]       pos_q, pos_d;
  logic signed [DataW-1:0] val_q;
  logic signed [DataW-1:0] root_q;
  logic [1:0]              stat_q;
  logic signed [DataW-1:0] rd_a_q, rd_b_q;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_stat_q;
  logic signed [DataW-1:0] out_min_q;
  logic [CountW-1:0]       out_cnt_q;
  logic                    out_empty_q;

  logic [CountW:0]         left_pos, right_pos;
  logic                    has_right, go_left;
  logic signed [DataW-1:0] child_min;
  logic [SlotW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
  logic                    wr_en;
  logic signed [DataW-1:0] wr_data;
  logic [CountW-1:0]       pos_m1, count_m1;

  // child positions, one based
  assign left_pos  = {pos_q, 1'b0};
  assign right_pos = {pos_q, 1'b1};
  assign has_right = (right_pos <= {1'b0, count_q});
  assign go_left   = !has_right || (rd_a_q < rd_b_q);
  assign child_min = go_left ? rd_a_q : rd_b_q;
  assign pos_m1    = pos_q - CountW'(1);
  assign count_m1  = count_q - CountW'(1);

  // status toward the controller
  always_comb begin
    logic [CountW-1:0] limit_eff;
    limit_eff = (limit_i > CountW'(MaxEntries)) ? CountW'(MaxEntries) : limit_i;
    stat_o.full       = (count_q >= limit_eff);
    stat_o.count_zero = (count_q == '0);
    stat_o.count_one  = (count_q == CountW'(1));
    stat_o.at_root    = (pos_q == CountW'(1));
    stat_o.up_swap    = (rd_a_q > val_q);
    stat_o.has_left   = (left_pos <= {1'b0, count_q});
    stat_o.down_swap  = (val_q > child_min);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // read addresses
  always_comb begin
    rd_addr_a = count_m1[SlotW-1:0];
    if (cmd_i.rd_up) begin
      rd_addr_a = pos_q[SlotW:1] - SlotW'(1);
    end else if (cmd_i.rd_dn) begin
      rd_addr_a = pos_m1[SlotW-1:0] + pos_q[SlotW-1:0];
    end
    rd_addr_b = left_pos[SlotW-1:0];
  end

  // write port, always at the current hole
  assign wr_addr = pos_m1[SlotW-1:0];
  assign wr_en   = cmd_i.move_up || cmd_i.move_down || cmd_i.write_final;
  always_comb begin
    priority if (cmd_i.move_up) begin
      wr_data = rd_a_q;
    end else if (cmd_i.move_down) begin
      wr_data = child_min;
    end else begin
      wr_data = val_q;
    end
  end

  // memory with registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  // count and hole position
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    if (cmd_i.load_push) begin
      count_d = count_q + CountW'(1);
      pos_d   = count_q + CountW'(1);
    end
    if (cmd_i.load_pop) begin
      count_d = count_m1;
      pos_d   = CountW'(1);
    end
    if (cmd_i.move_up) begin
      pos_d = pos_q >> 1;
    end
    if (cmd_i.move_down) begin
      pos_d = go_left ? left_pos[CountW-1:0] : right_pos[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // moving value, root mirror and status
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load_push) begin
      val_q <= push_value_i;
    end
    if (cmd_i.take_last) begin
      val_q <= rd_a_q;
    end
    if (wr_en && (wr_addr == '0)) begin
      root_q <= wr_data;
    end
    if (cmd_i.set_stat) begin
      stat_q <= cmd_i.stat;
    end
  end

  // output register
  assign out_valid_d = cmd_i.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_stat_q  <= stat_q;
      out_min_q   <= (count_q == '0) ? '0 : root_q;
      out_cnt_q   <= count_q;
      out_empty_q <= (count_q == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_stat_q;
  assign out_min_value_o   = out_min_q;
  assign out_entry_count_o = out_cnt_q;
  assign out_is_empty_o    = out_empty_q;

endmodule

FILE: rtl/core/bounded_min_heap_queue.sv
// Bounded min-heap priority queue of signed 32-bit values.
// Request channel (req): req_type selects push of push_value or pop of the
// minimum; a transfer happens when valid and ready are both high. ready is
// high only while no request is in work, so one request is handled at a time.
// Response channel (rsp): one transfer per request with status, min_value,
// entry_count and is_empty; min_value reads 0 on an empty heap.
// A full push, an empty pop and a pop of the last entry go straight to the
// response. A push otherwise sifts the new value up toward the root and a pop
// moves the last entry to the root and sifts it down; each level costs one
// read of the heap memory and one compare-and-write step.
// The response sits in an output register; the next request is taken while
// it waits, and a stalled receiver only holds the block in its final state
// until the output register frees up.
// APB port: one register at byte address 0, capacity_limit[4:0], reset 16;
// limits above 16 act as 16. pready is always high.
// Reset clears the entry count, the state machine and the output valid; heap
// contents need no clearing.
module bounded_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bmhq_req_if.sink          req,
  bmhq_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [CountW-1:0] cap_q;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // capacity register, single word so every offset decodes to it
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1:2 % PaddrW] == '0 || PaddrW <= 2)
                  ? PdataW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapResetVal;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CountW-1:0];
    end
  end

  bmhq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req.valid),
    .in_req_type_i(req.req_type),
    .in_ready_o   (req.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  bmhq_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .limit_i          (cap_q),
    .push_value_i     (req.push_value),
    .out_ready_i      (rsp.ready),
    .out_valid_o      (rsp.valid),
    .out_status_o     (rsp.status),
    .out_min_value_o  (rsp.min_value),
    .out_entry_count_o(rsp.entry_count),
    .out_is_empty_o   (rsp.is_empty)
  );

endmodule

FILE: rtl/core/bmhq_checker.sv
module bmhq_checker
  import bmhq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  bmhq_req_if.sink   req,
  bmhq_rsp_if.source rsp
);

  // count never goes past the storage depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.entry_count <= CountW'(MaxEntries)))
    else $error("entry count above heap depth");

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  // empty heap reports a zero minimum
  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.is_empty) |-> (rsp.min_value == '0))
    else $error("nonzero minimum on empty heap");

  // an ignored pop only happens on an empty heap
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.status == StatEmpty)) |-> rsp.is_empty)
    else $error("empty status with entries stored");

  // request side is held off while a request is in work
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in work");

endmodule

bind bounded_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req   (req),
  .rsp   (rsp)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmhq_pkg::*;

  localparam logic [PaddrW-1:0] CapLimitAddr  = '0;
  localparam int unsigned       WatchdogLimit = 2000;
  localparam int unsigned       SettleCycles  = 16;
  localparam int unsigned       PhaseItems    = 130;

  // expected response fields
  typedef struct {
    logic [1:0]              status;
    logic signed [DataW-1:0] min_value;
    logic [CountW-1:0]       entry_count;
    logic                    is_empty;
  } heap_rsp_t;

  // heap mirror plus queue of responses still owed
  class heap_scoreboard;
    logic signed [DataW-1:0] slots[MaxEntries];
    int unsigned             fill;
    logic [CountW-1:0]       cap;
    heap_rsp_t               owed[$];
    int unsigned             errors;

    function new();
      fill   = 0;
      cap    = CapResetVal;
      errors = 0;
    endfunction

    function void set_limit(input logic [CountW-1:0] lim);
      cap = lim;
    endfunction

    function void swap_slots(input int unsigned a, input int unsigned b);
      logic signed [DataW-1:0] tmp;
      tmp      = slots[a];
      slots[a] = slots[b];
      slots[b] = tmp;
    endfunction

    // apply one accepted request to the mirror and queue its response
    function void note_request(input logic kind, input logic signed [DataW-1:0] val);
      int unsigned lim, pos, l, r, nxt;
      bit          going;
      heap_rsp_t   res;
      lim = (cap > MaxEntries) ? MaxEntries : cap;
      res.status = StatDone;
      if (kind == ReqPush) begin
        if (fill >= lim) begin
          res.status = StatFull;
        end else begin
          slots[fill] = val;
          fill++;
          // sift up while the parent is larger, positions 1-based
          pos = fill;
          while (pos > 1 && slots[pos/2-1] > slots[pos-1]) begin
            swap_slots(pos/2-1, pos-1);
            pos = pos / 2;
          end
        end
      end else begin
        if (fill == 0) begin
          res.status = StatEmpty;
        end else begin
          fill--;
          slots[0] = slots[fill];
          // sift down, equal children go right
          pos   = 1;
          going = 1'b1;
          while (going) begin
            l = 2 * pos;
            r = l + 1;
            if (l > fill) begin
              going = 1'b0;
            end else if (r > fill) begin
              if (slots[pos-1] > slots[l-1]) swap_slots(pos-1, l-1);
              going = 1'b0;
            end else begin
              nxt = (slots[l-1] < slots[r-1]) ? l : r;
              if (slots[pos-1] <= slots[nxt-1]) begin
                going = 1'b0;
              end else begin
                swap_slots(pos-1, nxt-1);
                pos = nxt;
              end
            end
          end
        end
      end
      res.min_value   = (fill > 0) ? slots[0] : '0;
      res.entry_count = CountW'(fill);
      res.is_empty    = (fill == 0);
      owed.insert(owed.size(), res);
    endfunction

    // compare one response transfer with the oldest owed response
    function void check_result(input logic [1:0] status, input logic signed [DataW-1:0] minv,
                               input logic [CountW-1:0] cnt, input logic empty);
      heap_rsp_t want;
      if (owed.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      want = owed.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (minv !== want.min_value) begin
        $error("min_value: expected %0d, got %0d", want.min_value, minv);
        errors++;
      end
      if (cnt !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
        errors++;
      end
      if (empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              apb_psel;
  logic              apb_penable;
  logic              apb_pwrite;
  logic [PaddrW-1:0] apb_paddr;
  logic [PdataW-1:0] apb_pwdata;
  logic [PdataW-1:0] apb_prdata;
  logic              apb_pready;

  bit          idle_on = 1'b1;
  int unsigned stall_cycles = 0;

  heap_scoreboard sb = new();

  bmhq_req_if req_ch ();
  bmhq_rsp_if rsp_ch ();

  bounded_min_heap_queue DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (apb_psel),
    .penable (apb_penable),
    .pwrite  (apb_pwrite),
    .paddr   (apb_paddr),
    .pwdata  (apb_pwdata),
    .prdata  (apb_prdata),
    .pready  (apb_pready)
  );

  always #2 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < 19);
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(rsp_ch.status, rsp_ch.min_value, rsp_ch.entry_count, rsp_ch.is_empty);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || apb_psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request transfer, entered and left at a falling edge
  task automatic send_req(input logic kind, input logic signed [DataW-1:0] val);
    while (idle_on && $urandom_range(0, 99) < 19) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.push_value <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(kind, val);
    @(negedge clk_i);
  endtask

  // apb write of the capacity limit
  task automatic write_limit(input logic [CountW-1:0] lim);
    apb_psel    <= 1'b1;
    apb_penable <= 1'b0;
    apb_pwrite  <= 1'b1;
    apb_paddr   <= CapLimitAddr;
    apb_pwdata  <= PdataW'(lim);
    @(negedge clk_i);
    apb_penable <= 1'b1;
    do @(posedge clk_i); while (!apb_pready);
    sb.set_limit(lim);
    @(negedge clk_i);
    apb_psel    <= 1'b0;
    apb_penable <= 1'b0;
  endtask

  // stop sending, wait for all owed responses and let the block settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // values with extremes and many duplicates
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return int'($urandom_range(0, 7)) - 4;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned limits[12];
    int unsigned push_pct[12];

    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = ReqPush;
    req_ch.push_value = '0;
    apb_psel          = 1'b0;
    apb_penable       = 1'b0;
    apb_pwrite        = 1'b0;
    apb_paddr         = '0;
    apb_pwdata        = '0;

    limits   = '{16, 0, 16, 1, 31, 2, 17, 5, 16, 3, 8, 16};
    push_pct = '{75, 40, 60, 30, 80, 50, 65, 45, 70, 35, 55, 25};
    limits[7] = $urandom_range(0, 31);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty pop, fill with extremes and duplicates, full push
    send_req(ReqPop, 32'sh7fff_ffff);
    send_req(ReqPush, 32'sh7fff_ffff);
    send_req(ReqPush, 32'sh8000_0000);
    send_req(ReqPush, 0);
    send_req(ReqPush, -1);
    send_req(ReqPush, 5);
    send_req(ReqPush, 5);
    send_req(ReqPush, 5);
    send_req(ReqPush, 3);
    send_req(ReqPush, 3);
    send_req(ReqPush, -7);
    send_req(ReqPush, 100);
    send_req(ReqPush, 32'sh7fff_ffff);
    send_req(ReqPush, 32'sh8000_0000);
    send_req(ReqPush, 1);
    send_req(ReqPush, 1);
    send_req(ReqPush, 2);
    send_req(ReqPush, 9);
    repeat (4) send_req(ReqPop, $urandom());

    // limit lowered below the count
    drain();
    write_limit(1);
    send_req(ReqPush, 4);
    send_req(ReqPop, 32'sh8000_0000);

    // random phases over a range of limits
    for (int p = 0; p < 12; p++) begin
      drain();
      write_limit(CountW'(limits[p]));
      idle_on = (p != 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < push_pct[p]) send_req(ReqPush, pick_value());
        else send_req(ReqPop, $urandom());
      end
    end
    idle_on = 1'b1;

    drain();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
